[hdl/mro_pkg.sv]
// ----------------------------------------------------------------------------
// mro_pkg: shared types and constants for the modular exponentiation oracle
// Holds sequencer states, reduction step codes and register indexes.
// ----------------------------------------------------------------------------
package mro_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQR,
        ST_DIV,
        ST_DONE
    } state_t;

    // What the running reduction feeds back into
    typedef enum logic [1:0] {
        OP_BASE,
        OP_ACC,
        OP_SQR
    } op_t;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_Y_WIDTH = 3'd1;
    localparam logic [2:0] REG_BASE    = 3'd2;
    localparam logic [2:0] REG_MODULUS = 3'd3;
    localparam logic [2:0] REG_KEY_IN  = 3'd4;
    localparam logic [2:0] REG_KEY_OUT = 3'd5;

    localparam int CFG_WIDTH  = 32;
    localparam int DATA_WIDTH = 64;

endpackage

[hdl/modexp_register_oracle.sv]
// ----------------------------------------------------------------------------
// modexp_register_oracle: square-and-multiply register oracle
// Splits a 64-bit request into x and y, raises base to x (optionally
// whitened) modulo modulus, and returns (power ^ y) + (x << y_width).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall / reg_value. A request is taken at a
//   clock edge with in_valid high and in_stall low. in_stall is high while
//   a request is being worked on.
//   Output channel: out_valid / out_stall / oracle_value, from an output
//   register that holds while out_stall is high.
//   Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
//   Datapath: one shared multiplier feeds one restoring remainder unit that
//   retires one dividend bit per cycle. One request is in flight at a time.
//   A finished result waits in the sequencer while the output register is
//   still full and stalled.
//   Reset: registers return to mode 0, y_width 8, base 2, modulus 1, keys 0;
//   the block is idle and the output register empty.
// ----------------------------------------------------------------------------
module modexp_register_oracle #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mro_pkg::DATA_WIDTH-1:0]  reg_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mro_pkg::DATA_WIDTH-1:0]  oracle_value,
    input  logic                            cfg_write,
    input  logic [2:0]                      cfg_index,
    input  logic [mro_pkg::CFG_WIDTH-1:0]   cfg_data
);
    import mro_pkg::*;

    localparam int W      = MOD_WIDTH;
    localparam int PW     = 2 * MOD_WIDTH;
    localparam int CNT_W  = $clog2(PW);

    // Configuration registers
    logic         mode_reg;
    logic [5:0]   y_width_reg;
    logic [W-1:0] base_reg;
    logic [W-1:0] modulus_reg;
    logic [W-1:0] key_in_reg;
    logic [W-1:0] key_out_reg;

    // Sequencer and datapath registers
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [DATA_WIDTH-1:0] e_reg, e_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [DATA_WIDTH-1:0] xs_reg, xs_next;
    logic [W-1:0]          acc_reg, acc_next;
    logic [W-1:0]          b_reg, b_next;
    logic [W-1:0]          m_reg, m_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [W-1:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_reg, out_next;

    logic [DATA_WIDTH-1:0] ymask;
    logic [W-1:0]          mul_a;
    logic [PW-1:0]         mul_p;
    logic [W:0]            rem_shift;
    logic [W:0]            rem_step;
    logic [DATA_WIDTH-1:0] power;

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign oracle_value = out_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            y_width_reg <= 6'd8;
            base_reg    <= W'(2);
            modulus_reg <= W'(1);
            key_in_reg  <= '0;
            key_out_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[0];
                REG_Y_WIDTH: y_width_reg <= cfg_data[5:0];
                REG_BASE:    base_reg    <= cfg_data[W-1:0];
                REG_MODULUS: modulus_reg <= cfg_data[W-1:0];
                REG_KEY_IN:  key_in_reg  <= cfg_data[W-1:0];
                REG_KEY_OUT: key_out_reg <= cfg_data[W-1:0];
                default:     ;
            endcase
        end
    end

    // Shared multiplier and one restoring remainder step
    assign mul_a     = (state_reg == ST_CHECK) ? acc_reg : b_reg;
    assign mul_p     = PW'(mul_a) * PW'(b_reg);
    assign rem_shift = {rem_reg, prod_reg[PW-1]};
    assign rem_step  = (rem_shift >= {1'b0, m_reg}) ? (rem_shift - {1'b0, m_reg})
                                                     : rem_shift;
    assign ymask     = (DATA_WIDTH'(1) << y_width_reg) - DATA_WIDTH'(1);

    // Final power, whitened in Even-Mansour mode
    always_comb
    begin
        power = DATA_WIDTH'(acc_reg);
        if (mode_reg)
        begin
            power = power ^ DATA_WIDTH'(key_out_reg);
        end
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        e_next         = e_reg;
        y_next         = y_reg;
        xs_next        = xs_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        m_next         = m_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // Drop the result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    y_next    = reg_value & ymask;
                    xs_next   = reg_value & ~ymask;
                    e_next    = (reg_value >> y_width_reg)
                                ^ (mode_reg ? DATA_WIDTH'(key_in_reg) : '0);
                    m_next    = (modulus_reg == '0) ? W'(1) : modulus_reg;
                    acc_next  = W'(1);
                    prod_next = PW'(base_reg);
                    rem_next  = '0;
                    cnt_next  = CNT_W'(PW - 1);
                    op_next   = OP_BASE;
                    state_next = ST_DIV;
                end
            end
            ST_CHECK:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (e_reg[0])
                begin
                    prod_next  = mul_p;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(PW - 1);
                    op_next    = OP_ACC;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                prod_next  = mul_p;
                rem_next   = '0;
                cnt_next   = CNT_W'(PW - 1);
                op_next    = OP_SQR;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = rem_step[W-1:0];
                prod_next = {prod_reg[PW-2:0], 1'b0};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    unique case (op_reg)
                        OP_BASE:
                        begin
                            b_next     = rem_step[W-1:0];
                            state_next = ST_CHECK;
                        end
                        OP_ACC:
                        begin
                            acc_next   = rem_step[W-1:0];
                            state_next = ST_SQR;
                        end
                        OP_SQR:
                        begin
                            b_next     = rem_step[W-1:0];
                            e_next     = e_reg >> 1;
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_CHECK;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = (power ^ y_reg) + xs_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        e_reg    <= e_next;
        y_reg    <= y_next;
        xs_reg   <= xs_next;
        acc_reg  <= acc_next;
        b_reg    <= b_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

endmodule
